>>> rtl/core/taylor_sine_macros.svh
// assertion macros used by the taylor sine checker
`ifndef TAYLOR_SINE_MACROS_SVH
`define TAYLOR_SINE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TS_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TS_ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/core/ts_pkg.sv
// shared types, constants and arithmetic helpers of the taylor sine unit
package ts_pkg;

  localparam int FRAC_BITS     = 28;
  localparam int GUARD_BITS    = 6;
  localparam int MAX_TERMS_DEF = 8;
  localparam int TC_W          = 4;
  localparam logic [TC_W-1:0] TC_RESET = 4'd3;

  localparam int MAG_W      = 63;
  localparam int ACC_W      = 64;
  localparam int COEF_SHIFT = 62;
  localparam logic [MAG_W-1:0] MAG_CAP = 63'h4000_0000_0000_0000;

  typedef logic [MAG_W-1:0]        mag_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic signed [31:0] angle;
    logic               last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sine_value;
    logic               last_out;
  } out_item_t;

  // per-item context carried down the term pipeline
  typedef struct packed {
    mag_t x2;
    acc_t acc;
    logic neg;
    logic last;
  } ctx_t;

  typedef struct packed {
    ctx_t ctx;
    mag_t m;
  } mterm_t;

  typedef struct packed {
    logic [63:0] p0;
    logic [63:0] p1;
    logic [63:0] p2;
    logic [63:0] p3;
  } pp_t;

  typedef struct packed {
    ctx_t ctx;
    pp_t  pp;
  } ppst_t;

  // four partial products (32-bit low, 31-bit high halves) of a 63x63 multiply
  function automatic pp_t mul_pp(mag_t a, mag_t b);
    logic [31:0] al;
    logic [31:0] bl;
    logic [30:0] ah;
    logic [30:0] bh;
    pp_t         r;
    al   = a[31:0];
    ah   = a[62:32];
    bl   = b[31:0];
    bh   = b[62:32];
    r.p0 = al * bl;
    r.p1 = al * bh;
    r.p2 = ah * bl;
    r.p3 = ah * bh;
    return r;
  endfunction

  // sum partial products, round half up, shift right and clamp the magnitude
  function automatic mag_t rnd_shift(pp_t pp, int unsigned sh);
    logic [127:0] s;
    logic [127:0] q;
    s = {pp.p3, pp.p0} + {32'd0, pp.p1, 32'd0} + {32'd0, pp.p2, 32'd0}
        + (128'd1 << (sh - 1));
    q = s >> sh;
    if (q > 128'(MAG_CAP)) begin
      return MAG_CAP;
    end
    return q[MAG_W-1:0];
  endfunction

  // signed accumulate with saturation at +-2^62
  function automatic acc_t sat_add(acc_t acc, mag_t m, logic negative);
    acc_t room;
    acc_t cap;
    acc_t mv;
    room = acc_t'({1'b0, MAG_CAP - m});
    cap  = acc_t'({1'b0, MAG_CAP});
    mv   = acc_t'({1'b0, m});
    if (!negative) begin
      return (acc > room) ? cap : acc + mv;
    end
    return (acc < -room) ? -cap : acc - mv;
  endfunction

endpackage

>>> rtl/core/taylor_sine.sv
// taylor series sine unit: pipelined, one angle per cycle unless stalled
//
// channels: in_valid/in_ready/in_data carry an angle in signed Q4.28 and a
// last flag; out_valid/out_ready/out_data return the saturated sine in the
// same format with the last flag copied. cfg_valid/cfg_data write term_count
// (terms added after x, values above MAX_TERMS act as MAX_TERMS); cfg_ready
// is always high. write it only while no item is in flight.
// throughput: one item per cycle unless stalled. each series term takes four
// stages, two per 63x63 multiply (partial products, then sum/round/clamp);
// the sum is updated in parallel with the next term's first multiply.
// reset: all stage valids clear, term_count returns to 3.
// stall: while a result waits and out_ready is low the pipeline freezes
// with every item held; the first stage still takes one new item if empty.
module taylor_sine #(
  parameter int MAX_TERMS = ts_pkg::MAX_TERMS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  ts_pkg::in_item_t         in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output ts_pkg::out_item_t        out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [ts_pkg::TC_W-1:0]  cfg_data
);
  import ts_pkg::*;

  localparam int SH_X2 = 2 * FRAC_BITS;
  localparam int RND_W = MAG_W - GUARD_BITS;
  localparam logic [TC_W-1:0] TERM_LAST = TC_W'(MAX_TERMS);
  localparam logic ODD_LAST = 1'(MAX_TERMS % 2);

  logic [TC_W-1:0] tc_r;
  logic            ce;
  logic            en1;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r <= TC_RESET;
    end else if (cfg_valid) begin
      tc_r <= cfg_data;
    end
  end

  logic      out_vld_r;
  out_item_t out_r;
  out_item_t out_nxt;

  logic        s1_vld_r;
  logic [31:0] s1_mag_r;
  logic [31:0] s1_mag_nxt;
  logic        s1_neg_r;
  logic        s1_last_r;
  logic [31:0] ang_u;

  assign ce        = !out_vld_r || out_ready;
  assign en1       = ce || !s1_vld_r;
  assign in_ready  = en1;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // stage 1: magnitude and sign of the angle
  always_comb begin
    ang_u      = in_data.angle;
    s1_mag_nxt = ang_u[31] ? (32'd0 - ang_u) : ang_u;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en1) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_mag_r  <= s1_mag_nxt;
      s1_neg_r  <= ang_u[31];
      s1_last_r <= in_data.last_in;
    end
  end

  // stage 2: x squared, first term magnitude, empty sum
  mterm_t mt_r     [0:MAX_TERMS];
  logic   mt_vld_r [0:MAX_TERMS];
  mterm_t mt0_nxt;
  logic [63:0] sq;

  always_comb begin
    sq               = s1_mag_r * s1_mag_r;
    mt0_nxt.ctx.x2   = sq[MAG_W-1:0];
    mt0_nxt.ctx.acc  = '0;
    mt0_nxt.ctx.neg  = s1_neg_r;
    mt0_nxt.ctx.last = s1_last_r;
    mt0_nxt.m        = mag_t'(s1_mag_r) << GUARD_BITS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mt_vld_r[0] <= 1'b0;
    end else if (ce) begin
      mt_vld_r[0] <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      mt_r[0] <= mt0_nxt;
    end
  end

  // one block per series term: block k adds term k and computes term k+1
  for (genvar k = 0; k < MAX_TERMS; k++) begin : g_term
    localparam logic [TC_W-1:0] TERM = TC_W'(k);
    localparam logic            ODD  = 1'(k % 2);
    localparam logic [63:0]     DIV  = 64'((2 * (k + 1)) * (2 * (k + 1) + 1));
    localparam logic [63:0]     COEF = (64'(MAG_CAP) + (DIV >> 1)) / DIV;

    ppst_t  a1_r;
    ppst_t  a1_nxt;
    logic   a1_vld_r;
    mterm_t b1_r;
    mterm_t b1_nxt;
    logic   b1_vld_r;
    ppst_t  a2_r;
    ppst_t  a2_nxt;
    logic   a2_vld_r;
    mterm_t b2_nxt;

    always_comb begin
      a1_nxt.ctx = mt_r[k].ctx;
      if (TERM <= tc_r) begin
        a1_nxt.ctx.acc = sat_add(mt_r[k].ctx.acc, mt_r[k].m, ODD != mt_r[k].ctx.neg);
      end
      a1_nxt.pp  = mul_pp(mt_r[k].m, mt_r[k].ctx.x2);

      b1_nxt.ctx = a1_r.ctx;
      b1_nxt.m   = rnd_shift(a1_r.pp, SH_X2);

      a2_nxt.ctx = b1_r.ctx;
      a2_nxt.pp  = mul_pp(b1_r.m, mag_t'(COEF));

      b2_nxt.ctx = a2_r.ctx;
      b2_nxt.m   = rnd_shift(a2_r.pp, COEF_SHIFT);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a1_vld_r      <= 1'b0;
        b1_vld_r      <= 1'b0;
        a2_vld_r      <= 1'b0;
        mt_vld_r[k+1] <= 1'b0;
      end else if (ce) begin
        a1_vld_r      <= mt_vld_r[k];
        b1_vld_r      <= a1_vld_r;
        a2_vld_r      <= b1_vld_r;
        mt_vld_r[k+1] <= a2_vld_r;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        a1_r      <= a1_nxt;
        b1_r      <= b1_nxt;
        a2_r      <= a2_nxt;
        mt_r[k+1] <= b2_nxt;
      end
    end
  end

  // final sum, magnitude, rounding off the guard bits, saturation
  logic             fa_vld_r;
  acc_t             fa_acc_r;
  acc_t             fa_acc_nxt;
  logic             fa_last_r;
  logic             f1_vld_r;
  logic             f1_sneg_r;
  mag_t             f1_mag_r;
  acc_t             neg_acc;
  logic             f1_last_r;
  logic             f2_vld_r;
  logic             f2_sneg_r;
  logic [RND_W-1:0] f2_mag_r;
  logic [MAG_W:0]   rnd_sum;
  logic             f2_last_r;
  logic [RND_W-1:0] r2;

  always_comb begin
    fa_acc_nxt = mt_r[MAX_TERMS].ctx.acc;
    if (TERM_LAST <= tc_r) begin
      fa_acc_nxt = sat_add(mt_r[MAX_TERMS].ctx.acc, mt_r[MAX_TERMS].m,
                           ODD_LAST != mt_r[MAX_TERMS].ctx.neg);
    end
    neg_acc = -fa_acc_r;
    rnd_sum = {1'b0, f1_mag_r} + ((MAG_W + 1)'(1) << (GUARD_BITS - 1));
    r2      = f2_mag_r;
    out_nxt.last_out = f2_last_r;
    if (!f2_sneg_r) begin
      out_nxt.sine_value = (r2 > RND_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : r2[31:0];
    end else begin
      out_nxt.sine_value = (r2 > RND_W'(64'h8000_0000)) ? 32'h8000_0000
                                                        : (32'd0 - r2[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fa_vld_r  <= 1'b0;
      f1_vld_r  <= 1'b0;
      f2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (ce) begin
      fa_vld_r  <= mt_vld_r[MAX_TERMS];
      f1_vld_r  <= fa_vld_r;
      f2_vld_r  <= f1_vld_r;
      out_vld_r <= f2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      fa_acc_r  <= fa_acc_nxt;
      fa_last_r <= mt_r[MAX_TERMS].ctx.last;
      f1_sneg_r <= fa_acc_r[ACC_W-1];
      f1_mag_r  <= fa_acc_r[ACC_W-1] ? neg_acc[MAG_W-1:0] : fa_acc_r[MAG_W-1:0];
      f1_last_r <= fa_last_r;
      f2_sneg_r <= f1_sneg_r;
      f2_mag_r  <= RND_W'(rnd_sum >> GUARD_BITS);
      f2_last_r <= f1_last_r;
      out_r     <= out_nxt;
    end
  end

endmodule

>>> rtl/core/taylor_sine_chk.sv
// port-level checker for the taylor sine unit, bound to the top level
`include "taylor_sine_macros.svh"

module taylor_sine_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input ts_pkg::out_item_t out_data,
  input logic              cfg_ready
);
  import ts_pkg::*;

  // a waiting result holds until taken
  `TS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result item changed or dropped while stalled")

  // with the output register empty the pipeline always moves
  `TS_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !out_valid, in_ready, "input stalled with empty output")

  // nothing comes out right after reset
  `TS_ASSERT_IMP(a_reset_empty, clk, rst_n, $past(!rst_n), !out_valid, "result item right after reset")

  // configuration writes are never stalled
  `TS_ASSERT_IMP(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready, "configuration port not ready")

endmodule

bind taylor_sine taylor_sine_chk u_chk (.*);

>>> tb/sv/taylor_sine_test.sv
// testbench for the taylor sine unit: directed and random angles checked against a bit-exact series model
module taylor_sine_test;
  import ts_pkg::*;

  localparam int MAX_TERMS   = MAX_TERMS_DEF;
  localparam int LATENCY     = 4 * MAX_TERMS + 6;
  localparam int PHASE_ITEMS = 175;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam logic [31:0] PI_Q28 = 32'h3243_F6A9;

  class sine_scoreboard;
    localparam logic [63:0] TERM_CAP = 64'h4000_0000_0000_0000;

    logic [TC_W-1:0] terms;
    out_item_t       sine_q[$];
    int              mismatches;
    int              checked;
    int              saturated;

    function new();
      terms = TC_RESET;
    endfunction

    // round half up of a*b / 2^sh, clamped at the magnitude cap
    function logic [63:0] round_mul(logic [63:0] a, logic [63:0] b, int unsigned sh);
      logic [127:0] p;
      p = ({64'd0, a} * {64'd0, b}) + (128'd1 << (sh - 1));
      p = p >> sh;
      return (p > {64'd0, TERM_CAP}) ? TERM_CAP : p[63:0];
    endfunction

    function logic [31:0] sine_of(logic [31:0] angle, logic [TC_W-1:0] setting);
      logic [31:0]        mag;
      logic [63:0]        x2;
      logic [63:0]        m;
      logic [63:0]        d;
      logic [63:0]        coef;
      logic [63:0]        r;
      logic signed [63:0] acc;
      logic signed [63:0] room;
      int                 n;
      bit                 neg;
      bit                 down;
      neg = angle[31];
      mag = neg ? 32'd0 - angle : angle;
      x2  = {32'd0, mag} * {32'd0, mag};
      m   = {32'd0, mag} << GUARD_BITS;
      acc = neg ? -$signed(m) : $signed(m);
      n   = (setting > MAX_TERMS) ? MAX_TERMS : setting;
      for (int j = 1; j <= n; j++) begin
        d    = 64'(2 * j) * 64'(2 * j + 1);
        coef = (TERM_CAP + d / 2) / d;
        m    = round_mul(m, x2, 2 * FRAC_BITS);
        m    = round_mul(m, coef, COEF_SHIFT);
        down = ((j % 2) == 1) != neg;
        room = $signed(TERM_CAP - m);
        if (!down) begin
          acc = (acc > room) ? $signed(TERM_CAP) : acc + $signed(m);
        end else begin
          acc = (acc < -room) ? -$signed(TERM_CAP) : acc - $signed(m);
        end
      end
      r = acc[63] ? 64'd0 - $unsigned(acc) : $unsigned(acc);
      r = (r + (64'd1 << (GUARD_BITS - 1))) >> GUARD_BITS;
      if (!acc[63]) begin
        return (r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
      end
      return (r > 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - r[31:0];
    endfunction

    function void note_angle(in_item_t item);
      out_item_t want;
      want.sine_value = sine_of(item.angle, terms);
      want.last_out   = item.last_in;
      if (want.sine_value == 32'h7FFF_FFFF || want.sine_value == 32'h8000_0000) begin
        saturated++;
      end
      sine_q.push_back(want);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (sine_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected item: sine %h last %b", got.sine_value, got.last_out);
        end
        return;
      end
      want = sine_q.pop_front();
      checked++;
      if (got.sine_value !== want.sine_value || got.last_out !== want.last_out) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at item %0d: sine %h last %b, expected sine %h last %b",
                   checked, got.sine_value, got.last_out, want.sine_value, want.last_out);
        end
      end
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  in_item_t        in_data;
  logic            out_valid;
  logic            out_ready;
  out_item_t       out_data;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [TC_W-1:0] cfg_data;

  sine_scoreboard  sb;
  bit              calm;
  bit              hold_req;
  int              quiet_cycles;
  int              stall_run;
  int              longest_stall;
  int              settings_used;

  taylor_sine #(.MAX_TERMS(MAX_TERMS)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result checking, stall tracking and the watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
      end
      if (in_valid && !in_ready) begin
        stall_run++;
        if (stall_run > longest_stall) begin
          longest_stall = stall_run;
        end
      end else begin
        stall_run = 0;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("taylor_sine verification failed");
        $finish;
      end
    end
  end

  // result side: random backpressure, plus one long hold when asked
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 9);
      end
    end
  end

  task automatic send_angle(logic [31:0] angle, logic last);
    in_item_t item;
    item.angle   = angle;
    item.last_in = last;
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_angle(item);
    @(negedge clk);
  endtask

  task automatic write_terms(logic [TC_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.terms = value;
    settings_used++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.sine_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_angle();
    case ($urandom_range(9))
      0, 1, 2: return $urandom();
      3, 4, 5, 6: return $urandom_range(2 * PI_Q28) - PI_Q28;
      7: return $urandom_range(32'h8000_0000) - 32'h4000_0000;
      8: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(255)
                                  : 32'h8000_0000 + $urandom_range(255);
      default: return $urandom_range(2047) - 1024;
    endcase
  endfunction

  logic [31:0]     directed [$];
  logic [TC_W-1:0] phase_terms [10];

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    sb        = new();
    directed  = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h1000_0000,
                  32'hF000_0000, 32'h1921_FB54, 32'hE6DE_04AC, PI_Q28,
                  32'd0 - PI_Q28, 32'h6487_ED51, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h8000_0001, 32'h4000_0000, 32'hC000_0000, 32'h0000_0020,
                  32'h5555_5555, 32'hAAAA_AAAA, 32'h2000_0000, 32'hE000_0000};
    phase_terms = '{4'd0, 4'd15, 4'd8, 4'd1, 4'd5, 4'd2, 4'd9, 4'd7, 4'd4, 4'd6};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset setting: corner angles, saturation both ways, both flag values
    foreach (directed[i]) begin
      send_angle(directed[i], i[0]);
    end
    in_valid <= 1'b0;

    foreach (phase_terms[p]) begin
      wait_drained();
      write_terms(phase_terms[p]);
      calm = (p == 2);
      if (p == 4 || p == 7) begin
        hold_req = 1'b1;
      end
      repeat (PHASE_ITEMS) begin
        send_angle(pick_angle(), $urandom_range(7) == 0);
      end
      in_valid <= 1'b0;
    end
    calm = 1'b0;

    wait_drained();
    repeat (LATENCY + 8) @(negedge clk);
    $display("checked %0d sine results over %0d term settings, %0d of them saturated",
             sb.checked, settings_used + 1, sb.saturated);
    $display("longest input stall %0d cycles under result backpressure", longest_stall);
    if (sb.mismatches == 0 && sb.sine_q.size() == 0) begin
      $display("taylor_sine verification clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.mismatches, sb.sine_q.size());
      $display("taylor_sine verification failed");
    end
    $finish;
  end

endmodule
